// ===== design/b64e_pkg.sv =====
package b64e_pkg;

  localparam int LC_W = 7;
  localparam int LINE_LEN_DEF = 76;
  localparam int Q_DEPTH = 2;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      final_idx;
    logic            last;
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== design/b64e_front.sv =====
module b64e_front
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output job_t       job
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] lo_r, lo_nxt;

  always_comb begin
    job = '0;
    job.last = end_of_message;
    phase_nxt = phase_r;
    lo_nxt = lo_r;
    case (phase_r)
      2'd1: begin
        job.chars[0] = sextet_char({lo_r[1:0], data_byte[7:4]});
        if (end_of_message) begin
          job.chars[1] = sextet_char({data_byte[3:0], 2'b00});
          job.chars[2] = CHAR_PAD;
          job.final_idx = 2'd2;
        end
        phase_nxt = 2'd2;
        lo_nxt = data_byte[3:0];
      end
      2'd2: begin
        job.chars[0] = sextet_char({lo_r, data_byte[7:6]});
        job.chars[1] = sextet_char(data_byte[5:0]);
        job.final_idx = 2'd1;
        phase_nxt = 2'd0;
        lo_nxt = 4'd0;
      end
      default: begin
        job.chars[0] = sextet_char(data_byte[7:2]);
        if (end_of_message) begin
          job.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
          job.chars[2] = CHAR_PAD;
          job.chars[3] = CHAR_PAD;
          job.final_idx = 2'd3;
        end
        phase_nxt = 2'd1;
        lo_nxt = {2'b00, data_byte[1:0]};
      end
    endcase
    if (end_of_message) begin
      phase_nxt = 2'd0;
      lo_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      lo_r <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      lo_r <= lo_nxt;
    end
  end

endmodule

// ===== design/b64e_queue.sv =====
module b64e_queue
  import b64e_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  job_t                         din,
  output logic                         full,
  input  logic                         pop,
  output job_t                         dout,
  output logic                         valid,
  output logic [$clog2(Q_DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  job_t          mem_r [Q_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = mem_r[rp_r];
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/b64e_back.sv =====
module b64e_back
  import b64e_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       line_breaks_on,
  input  job_t       job,
  input  logic       job_valid,
  output logic       job_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  typedef enum logic [2:0] {
    ST_CHAR = 3'b001,
    ST_CR   = 3'b010,
    ST_LF   = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic [LC_W-1:0] lc_r, lc_nxt;
  logic            last_pend_r, last_pend_nxt;
  logic            vld_r, vld_nxt;
  logic [7:0]      char_r, char_nxt;
  logic            tlast_r, tlast_nxt;
  logic            slot_free, load, is_final, wrap;
  logic [LC_W-1:0] lc_inc;

  assign slot_free = !vld_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    lc_nxt = lc_r;
    last_pend_nxt = last_pend_r;
    char_nxt = char_r;
    tlast_nxt = tlast_r;
    load = 1'b0;
    job_pop = 1'b0;
    is_final = (idx_r == job.final_idx);
    lc_inc = lc_r + 1'b1;
    wrap = line_breaks_on && (lc_inc == LC_W'(LINE_LEN));
    case (state_r)
      ST_CHAR: begin
        if (job_valid && slot_free) begin
          load = 1'b1;
          char_nxt = job.chars[idx_r];
          tlast_nxt = job.last && is_final && !wrap;
          if (line_breaks_on) begin
            lc_nxt = wrap ? '0 : lc_inc;
          end
          if (is_final) begin
            job_pop = 1'b1;
            idx_nxt = 2'd0;
            if (job.last) begin
              lc_nxt = '0;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
          if (wrap) begin
            state_nxt = ST_CR;
            last_pend_nxt = job.last && is_final;
          end
        end
      end
      ST_CR: begin
        if (slot_free) begin
          load = 1'b1;
          char_nxt = CHAR_CR;
          tlast_nxt = 1'b0;
          state_nxt = ST_LF;
        end
      end
      ST_LF: begin
        if (slot_free) begin
          load = 1'b1;
          char_nxt = CHAR_LF;
          tlast_nxt = last_pend_r;
          state_nxt = ST_CHAR;
        end
      end
      default: begin
        state_nxt = ST_CHAR;
      end
    endcase
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CHAR;
      idx_r <= 2'd0;
      lc_r <= '0;
      last_pend_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      lc_r <= lc_nxt;
      last_pend_r <= last_pend_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    tlast_r <= tlast_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = char_r;
  assign out_tlast  = tlast_r;

endmodule

// ===== design/base64_line_wrapping_encoder.sv =====
// Base64 encoder with optional line wrapping. Each input transfer carries one
// message byte (in_tlast marks the final byte); each output transfer carries
// one ASCII character, with out_tlast on the final character of the message
// (the LF when a line break follows it). A byte is taken whenever the queue
// has room, and its characters (one to four, plus CR LF at a line end) leave
// at one per cycle from the output register while out_tready is high, so the
// output port sets the throughput. A two-entry queue separates byte
// intake from character output. With cfg_wdata = 1 (reset value) CR LF
// follows every LINE_LEN characters; write the register only while the
// block is idle.
module base64_line_wrapping_encoder
  import b64e_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // end_of_message
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,  // last_char
  input  logic       cfg_we,
  input  logic       cfg_wdata   // line_breaks_on
);

  logic                         line_breaks_on_r;
  logic                         accept, q_full, q_valid, q_pop;
  job_t                         f_job, q_job;
  logic [$clog2(Q_DEPTH+1)-1:0] q_count;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_breaks_on_r <= 1'b1;
    end else if (cfg_we) begin
      line_breaks_on_r <= cfg_wdata;
    end
  end

  b64e_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .data_byte      (in_tdata),
    .end_of_message (in_tlast),
    .job            (f_job)
  );

  b64e_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (f_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_job),
    .valid (q_valid),
    .count (q_count)
  );

  b64e_back #(
    .LINE_LEN (LINE_LEN)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .line_breaks_on (line_breaks_on_r),
    .job            (q_job),
    .job_valid      (q_valid),
    .job_pop        (q_pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast)
  );

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_cr_then_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata == CHAR_CR |=> out_tvalid && out_tdata == CHAR_LF)
    else $error("CR not followed by LF");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= ($clog2(Q_DEPTH+1))'(Q_DEPTH))
    else $error("queue overflow");

endmodule
